@@ design/mcwg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcwg_pkg
// Shared types and constants of the motion command watchdog gate.
// ----------------------------------------------------------------------------
package mcwg_pkg;

  localparam int unsigned NumLanes  = 3;
  localparam int unsigned LaneVx    = 0;
  localparam int unsigned LaneVy    = 1;
  localparam int unsigned LaneYaw   = 2;

  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned LimitW    = 15;
  localparam int unsigned SpeedW    = 16;
  localparam int unsigned TimeW     = 32;

  localparam logic [CfgIdxW-1:0] CFG_MAX_VX   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_VY   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_YAW  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_DEADBAND = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_WD_PER   = 3'd4;

  localparam logic [LimitW-1:0] RST_MAX_VX   = 15'd4096;
  localparam logic [LimitW-1:0] RST_MAX_VY   = 15'd2048;
  localparam logic [LimitW-1:0] RST_MAX_YAW  = 15'd4096;
  localparam logic [LimitW-1:0] RST_DEADBAND = 15'd0;
  localparam logic [TimeW-1:0]  RST_WD_PER   = 32'd500;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_MOVE = 2'd1,
    ACT_STOP = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    RSN_IDLE     = 3'd0,
    RSN_INVALID  = 3'd1,
    RSN_RANGE    = 3'd2,
    RSN_ZERO     = 3'd3,
    RSN_TARGET   = 3'd4,
    RSN_BAD_TIME = 3'd5,
    RSN_TIMEOUT  = 3'd6,
    RSN_PERIODIC = 3'd7
  } reason_e;

  // per-axis findings of one lane
  typedef struct packed {
    logic                     over;
    logic                     zero;
    logic signed [SpeedW-1:0] value;
  } lane_res_t;

  typedef struct packed {
    action_e                  action;
    logic signed [SpeedW-1:0] out_vx;
    logic signed [SpeedW-1:0] out_vy;
    logic signed [SpeedW-1:0] out_yaw;
    reason_e                  reason_code;
  } out_item_t;

endpackage

@@ design/mcwg_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcwg_if
// Channel interfaces: command/tick input, result output, register writes.
// ----------------------------------------------------------------------------
interface mcwg_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic               format_error;
  logic signed [15:0] cmd_vx;
  logic signed [15:0] cmd_vy;
  logic signed [15:0] cmd_yaw;
  logic [31:0]        now;

  modport source (output valid, kind, format_error, cmd_vx, cmd_vy, cmd_yaw, now,
                  input ready);
  modport sink (input valid, kind, format_error, cmd_vx, cmd_vy, cmd_yaw, now,
                output ready);
endinterface

interface mcwg_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [15:0] out_vx;
  logic signed [15:0] out_vy;
  logic signed [15:0] out_yaw;
  logic [2:0]         reason_code;

  modport source (output valid, action, out_vx, out_vy, out_yaw, reason_code,
                  input ready);
  modport sink (input valid, action, out_vx, out_vy, out_yaw, reason_code,
                output ready);
endinterface

interface mcwg_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ design/motion_command_watchdog_gate_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motion_command_watchdog_gate_core
// Velocity command gate with limit, deadband and watchdog checks.
// ----------------------------------------------------------------------------
// One transaction is taken every clock cycle while input is not stalled, and
// each gives exactly one registered result. Three axis lanes check limit
// and deadband in parallel and a merge stage decides the action and updates
// the target in the same cycle; a two-entry output buffer (register plus
// skid entry) lets input keep flowing while a result waits, and input stalls
// only when both entries are held. Register writes are always ready.
module motion_command_watchdog_gate_core (
  input  logic  clk_i,
  input  logic  rst_ni,
  mcwg_in_if.sink    in_i,
  mcwg_out_if.source out_o,
  mcwg_cfg_if.sink   cfg_i
);
  import mcwg_pkg::*;

  logic [LimitW-1:0]        max_vx_q, max_vy_q, max_yaw_q, deadband_q;
  logic [TimeW-1:0]         wd_period_q;
  logic                     cfg_fire;
  logic                     accept;
  logic                     in_ready;
  logic signed [SpeedW-1:0] lane_cmd   [NumLanes];
  logic [LimitW-1:0]        lane_limit [NumLanes];
  lane_res_t                lane_res   [NumLanes];
  out_item_t                item;

  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_vx_q    <= RST_MAX_VX;
      max_vy_q    <= RST_MAX_VY;
      max_yaw_q   <= RST_MAX_YAW;
      deadband_q  <= RST_DEADBAND;
      wd_period_q <= RST_WD_PER;
    end else if (cfg_fire) begin
      unique case (cfg_i.index)
        CFG_MAX_VX:   max_vx_q    <= cfg_i.data[LimitW-1:0];
        CFG_MAX_VY:   max_vy_q    <= cfg_i.data[LimitW-1:0];
        CFG_MAX_YAW:  max_yaw_q   <= cfg_i.data[LimitW-1:0];
        CFG_DEADBAND: deadband_q  <= cfg_i.data[LimitW-1:0];
        CFG_WD_PER:   wd_period_q <= cfg_i.data[TimeW-1:0];
        default: ;
      endcase
    end
  end

  assign lane_cmd[LaneVx]    = in_i.cmd_vx;
  assign lane_cmd[LaneVy]    = in_i.cmd_vy;
  assign lane_cmd[LaneYaw]   = in_i.cmd_yaw;
  assign lane_limit[LaneVx]  = max_vx_q;
  assign lane_limit[LaneVy]  = max_vy_q;
  assign lane_limit[LaneYaw] = max_yaw_q;

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    mcwg_axis_lane u_lane (
      .cmd_i      (lane_cmd[g]),
      .limit_i    (lane_limit[g]),
      .deadband_i (deadband_q),
      .res_o      (lane_res[g])
    );
  end

  assign accept     = in_i.valid & in_ready;
  assign in_i.ready = in_ready;

  mcwg_merge u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .kind_i         (in_i.kind),
    .format_error_i (in_i.format_error),
    .now_i          (in_i.now),
    .lane_i         (lane_res),
    .wd_period_i    (wd_period_q),
    .out_ready_i    (out_o.ready),
    .in_ready_o     (in_ready),
    .out_valid_o    (out_o.valid),
    .out_item_o     (item)
  );

  assign out_o.action      = item.action;
  assign out_o.out_vx      = item.out_vx;
  assign out_o.out_vy      = item.out_vy;
  assign out_o.out_yaw     = item.out_yaw;
  assign out_o.reason_code = item.reason_code;

endmodule

@@ design/mcwg_axis_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcwg_axis_lane
// One axis: magnitude, limit check and deadband.
// ----------------------------------------------------------------------------
module mcwg_axis_lane (
  input  logic signed [mcwg_pkg::SpeedW-1:0] cmd_i,
  input  logic [mcwg_pkg::LimitW-1:0]        limit_i,
  input  logic [mcwg_pkg::LimitW-1:0]        deadband_i,
  output mcwg_pkg::lane_res_t                res_o
);
  import mcwg_pkg::*;

  logic [SpeedW-1:0] mag;
  logic              in_band;

  // most negative input gives 0x8000, which is the right unsigned magnitude
  assign mag     = cmd_i[SpeedW-1] ? (~cmd_i + 1'b1) : cmd_i;
  assign in_band = mag <= {1'b0, deadband_i};

  assign res_o.over  = mag > {1'b0, limit_i};
  assign res_o.zero  = in_band;
  assign res_o.value = in_band ? '0 : cmd_i;

endmodule

@@ design/mcwg_merge.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcwg_merge
// Combines lane findings, keeps target and watchdog state, buffers results.
// ----------------------------------------------------------------------------
module mcwg_merge (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic                       kind_i,
  input  logic                       format_error_i,
  input  logic [mcwg_pkg::TimeW-1:0] now_i,
  input  mcwg_pkg::lane_res_t        lane_i [mcwg_pkg::NumLanes],
  input  logic [mcwg_pkg::TimeW-1:0] wd_period_i,
  input  logic                       out_ready_i,
  output logic                       in_ready_o,
  output logic                       out_valid_o,
  output mcwg_pkg::out_item_t        out_item_o
);
  import mcwg_pkg::*;

  logic                     active_q, active_d;
  logic signed [SpeedW-1:0] tgt_vx_q, tgt_vy_q, tgt_yaw_q;
  logic signed [SpeedW-1:0] tgt_vx_d, tgt_vy_d, tgt_yaw_d;
  logic [TimeW-1:0]         last_q, last_d;
  out_item_t                res;
  out_item_t                o_q, s_q;
  logic                     o_valid_q, s_valid_q;
  logic                     o_fire;
  logic                     any_over, all_zero;
  logic [TimeW-1:0]         age;

  assign any_over = lane_i[LaneVx].over | lane_i[LaneVy].over | lane_i[LaneYaw].over;
  assign all_zero = lane_i[LaneVx].zero & lane_i[LaneVy].zero & lane_i[LaneYaw].zero;
  assign age      = now_i - last_q;

  always_comb begin
    res       = '{action: ACT_STOP, out_vx: '0, out_vy: '0, out_yaw: '0,
                  reason_code: RSN_IDLE};
    active_d  = active_q;
    tgt_vx_d  = tgt_vx_q;
    tgt_vy_d  = tgt_vy_q;
    tgt_yaw_d = tgt_yaw_q;
    last_d    = last_q;
    if (!kind_i) begin
      if (format_error_i) begin
        res.reason_code = RSN_INVALID;
      end else if (any_over) begin
        res.reason_code = RSN_RANGE;
      end else if (all_zero) begin
        res.reason_code = RSN_ZERO;
      end else begin
        res.action      = ACT_NONE;
        res.reason_code = RSN_TARGET;
        res.out_vx      = lane_i[LaneVx].value;
        res.out_vy      = lane_i[LaneVy].value;
        res.out_yaw     = lane_i[LaneYaw].value;
      end
    end else if (!active_q) begin
      res.action = ACT_NONE;
    end else if (now_i < last_q) begin
      res.reason_code = RSN_BAD_TIME;
    end else if (age >= wd_period_i) begin
      res.reason_code = RSN_TIMEOUT;
    end else begin
      res.action      = ACT_MOVE;
      res.reason_code = RSN_PERIODIC;
      res.out_vx      = tgt_vx_q;
      res.out_vy      = tgt_vy_q;
      res.out_yaw     = tgt_yaw_q;
    end

    if (res.action == ACT_STOP) begin
      active_d  = 1'b0;
      tgt_vx_d  = '0;
      tgt_vy_d  = '0;
      tgt_yaw_d = '0;
    end else if (res.reason_code == RSN_TARGET) begin
      active_d  = 1'b1;
      tgt_vx_d  = res.out_vx;
      tgt_vy_d  = res.out_vy;
      tgt_yaw_d = res.out_yaw;
      last_d    = now_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      tgt_vx_q  <= '0;
      tgt_vy_q  <= '0;
      tgt_yaw_q <= '0;
      last_q    <= '0;
    end else if (accept_i) begin
      active_q  <= active_d;
      tgt_vx_q  <= tgt_vx_d;
      tgt_vy_q  <= tgt_vy_d;
      tgt_yaw_q <= tgt_yaw_d;
      last_q    <= last_d;
    end
  end

  // output register plus skid entry
  assign o_fire     = o_valid_q & out_ready_i;
  assign in_ready_o = ~s_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
      s_valid_q <= 1'b0;
    end else if (accept_i) begin
      if (!o_valid_q || o_fire) begin
        o_valid_q <= 1'b1;
      end else begin
        s_valid_q <= 1'b1;
      end
    end else if (o_fire) begin
      o_valid_q <= s_valid_q;
      s_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      if (!o_valid_q || o_fire) begin
        o_q <= res;
      end else begin
        s_q <= res;
      end
    end else if (o_fire && s_valid_q) begin
      o_q <= s_q;
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_item_o  = o_q;

`ifndef SYNTHESIS
  a_stop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_valid_q && o_q.action == ACT_STOP) |->
      (o_q.out_vx == '0 && o_q.out_vy == '0 && o_q.out_yaw == '0))
    else $error("stop result with nonzero speed");
  a_stop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && res.action == ACT_STOP) |=> !active_q)
    else $error("gate still active after stop");
  a_active_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (tgt_vx_q != '0 || tgt_vy_q != '0 || tgt_yaw_q != '0))
    else $error("active gate with all-zero target");
  a_idle_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && kind_i && !active_q) |-> (res.action == ACT_NONE &&
      res.reason_code == RSN_IDLE))
    else $error("tick while inactive did not report idle");
  a_skid_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_valid_q |-> o_valid_q)
    else $error("skid entry holds data while output register is empty");
`endif

endmodule

@@ test/mcwg_tb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcwg_tb_pkg
// Command kind codes shared by the gate checks and the stimulus.
// ----------------------------------------------------------------------------
package mcwg_tb_pkg;

  localparam logic KIND_PACKET = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

endpackage

@@ test/mcwg_decision_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcwg_decision_check
// Watches the command, result and register channels of the gate, works out
// the expected decision for every command transaction and compares results.
// ----------------------------------------------------------------------------
module mcwg_decision_check (
  input  logic clk_i,
  input  logic rst_ni,
  mcwg_in_if   cmd_i,
  mcwg_out_if  res_i,
  mcwg_cfg_if  cfg_i,
  output int   mismatch_count_o,
  output int   awaited_count_o
);
  import mcwg_pkg::*;
  import mcwg_tb_pkg::*;

  logic [LimitW-1:0]        lim_vx, lim_vy, lim_yaw, db_lvl;
  logic [TimeW-1:0]         wd_period;
  logic                     active;
  logic signed [SpeedW-1:0] tgt_vx, tgt_vy, tgt_yaw;
  logic [TimeW-1:0]         last_cmd_time;
  out_item_t                pending_decisions[$];
  out_item_t                oldest;

  function automatic int unsigned magnitude(input logic signed [SpeedW-1:0] v);
    int s;
    s = int'(v);
    return (s < 0) ? -s : s;
  endfunction

  function automatic logic signed [SpeedW-1:0] squelch(input logic signed [SpeedW-1:0] v);
    return (magnitude(v) <= db_lvl) ? '0 : v;
  endfunction

  function automatic out_item_t stop_gate(input reason_e why);
    out_item_t r;
    active      = 1'b0;
    tgt_vx      = '0;
    tgt_vy      = '0;
    tgt_yaw     = '0;
    r.action      = ACT_STOP;
    r.out_vx      = '0;
    r.out_vy      = '0;
    r.out_yaw     = '0;
    r.reason_code = why;
    return r;
  endfunction

  function automatic out_item_t decide_gate(input logic kind, input logic fmt_err,
                                            input logic signed [SpeedW-1:0] vx,
                                            input logic signed [SpeedW-1:0] vy,
                                            input logic signed [SpeedW-1:0] yaw,
                                            input logic [TimeW-1:0] stamp);
    out_item_t r;
    logic signed [SpeedW-1:0] dvx, dvy, dyaw;
    r.action      = ACT_NONE;
    r.out_vx      = '0;
    r.out_vy      = '0;
    r.out_yaw     = '0;
    r.reason_code = RSN_IDLE;
    if (kind == KIND_PACKET) begin
      if (fmt_err) begin
        r = stop_gate(RSN_INVALID);
      end else if (magnitude(vx) > lim_vx || magnitude(vy) > lim_vy ||
                   magnitude(yaw) > lim_yaw) begin
        r = stop_gate(RSN_RANGE);
      end else begin
        dvx  = squelch(vx);
        dvy  = squelch(vy);
        dyaw = squelch(yaw);
        if (dvx == 0 && dvy == 0 && dyaw == 0) begin
          r = stop_gate(RSN_ZERO);
        end else begin
          tgt_vx        = dvx;
          tgt_vy        = dvy;
          tgt_yaw       = dyaw;
          last_cmd_time = stamp;
          active        = 1'b1;
          r.out_vx      = dvx;
          r.out_vy      = dvy;
          r.out_yaw     = dyaw;
          r.reason_code = RSN_TARGET;
        end
      end
    end else if (active) begin
      if (stamp < last_cmd_time) begin
        r = stop_gate(RSN_BAD_TIME);
      end else if (stamp - last_cmd_time >= wd_period) begin
        r = stop_gate(RSN_TIMEOUT);
      end else begin
        r.action      = ACT_MOVE;
        r.out_vx      = tgt_vx;
        r.out_vy      = tgt_vy;
        r.out_yaw     = tgt_yaw;
        r.reason_code = RSN_PERIODIC;
      end
    end
    return r;
  endfunction

  function automatic void compare_field(input string name, input logic [SpeedW-1:0] want,
                                        input logic [SpeedW-1:0] seen);
    if (seen !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, seen);
      mismatch_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_vx        = RST_MAX_VX;
      lim_vy        = RST_MAX_VY;
      lim_yaw       = RST_MAX_YAW;
      db_lvl        = RST_DEADBAND;
      wd_period     = RST_WD_PER;
      active        = 1'b0;
      tgt_vx        = '0;
      tgt_vy        = '0;
      tgt_yaw       = '0;
      last_cmd_time = '0;
      pending_decisions.delete();
      awaited_count_o  = 0;
      mismatch_count_o = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_MAX_VX:   lim_vx    = cfg_i.data[LimitW-1:0];
          CFG_MAX_VY:   lim_vy    = cfg_i.data[LimitW-1:0];
          CFG_MAX_YAW:  lim_yaw   = cfg_i.data[LimitW-1:0];
          CFG_DEADBAND: db_lvl    = cfg_i.data[LimitW-1:0];
          CFG_WD_PER:   wd_period = cfg_i.data;
          default: ;
        endcase
      end
      if (cmd_i.valid && cmd_i.ready) begin
        pending_decisions.push_back(decide_gate(cmd_i.kind, cmd_i.format_error, cmd_i.cmd_vx,
                                                cmd_i.cmd_vy, cmd_i.cmd_yaw, cmd_i.now));
      end
      if (res_i.valid && res_i.ready) begin
        if (pending_decisions.size() == 0) begin
          $error("result transaction with no command awaiting it");
          mismatch_count_o++;
        end else begin
          oldest = pending_decisions.pop_front();
          compare_field("action", SpeedW'(oldest.action), SpeedW'(res_i.action));
          compare_field("out_vx", oldest.out_vx, res_i.out_vx);
          compare_field("out_vy", oldest.out_vy, res_i.out_vy);
          compare_field("out_yaw", oldest.out_yaw, res_i.out_yaw);
          compare_field("reason_code", SpeedW'(oldest.reason_code),
                        SpeedW'(res_i.reason_code));
        end
      end
      awaited_count_o = pending_decisions.size();
    end
  end

endmodule

@@ test/motion_command_watchdog_gate_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motion_command_watchdog_gate_core_test
// Drives commands and ticks into the gate under several register settings,
// with random gaps and result stalls; decision_check predicts and compares.
// ----------------------------------------------------------------------------
module motion_command_watchdog_gate_core_test;
  import mcwg_pkg::*;
  import mcwg_tb_pkg::*;

  localparam logic [CfgIdxW-1:0] CFG_SPARE = 3'd7;  // not a register, must be ignored
  localparam int unsigned RandomCommands = 1225;
  localparam int unsigned SettingRounds  = 6;
  localparam int unsigned StallCycles    = 48;

  logic clk_i;
  logic rst_ni;

  mcwg_in_if  cmd_ch();
  mcwg_out_if res_ch();
  mcwg_cfg_if cfg_ch();

  int          mismatch_count;
  int          awaited_count;
  int unsigned send_idle_pct   = 38;
  int unsigned recv_idle_pct   = 79;
  int unsigned holds_requested = 0;

  // register contents as last written, used to shape commands
  logic [LimitW-1:0] cur_lim_vx, cur_lim_vy, cur_lim_yaw, cur_db;
  logic [TimeW-1:0]  cur_wd;
  logic [TimeW-1:0]  clock_now, last_sent_stamp;

  motion_command_watchdog_gate_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_ch),
    .out_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  mcwg_decision_check decision_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd_ch),
    .res_i            (res_ch),
    .cfg_i            (cfg_ch),
    .mismatch_count_o (mismatch_count),
    .awaited_count_o  (awaited_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int unsigned holds_done;
    holds_done   = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (holds_requested > holds_done) begin
        res_ch.ready <= 1'b0;
        repeat (StallCycles) @(negedge clk_i);
        holds_done++;
      end else begin
        res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  task automatic offer_command(input logic kind, input logic fmt_err,
                               input logic signed [SpeedW-1:0] vx,
                               input logic signed [SpeedW-1:0] vy,
                               input logic signed [SpeedW-1:0] yaw,
                               input logic [TimeW-1:0] stamp);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    cmd_ch.valid        <= 1'b1;
    cmd_ch.kind         <= kind;
    cmd_ch.format_error <= fmt_err;
    cmd_ch.cmd_vx       <= vx;
    cmd_ch.cmd_vy       <= vy;
    cmd_ch.cmd_yaw      <= yaw;
    cmd_ch.now          <= stamp;
    @(posedge clk_i);
    while (!cmd_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // waits for the gate to drain, then writes every register; upper data
  // bits of the 15 bit registers carry junk that must be masked
  task automatic program_limits(input logic [LimitW-1:0] lx, input logic [LimitW-1:0] ly,
                                input logic [LimitW-1:0] lyaw, input logic [LimitW-1:0] db,
                                input logic [TimeW-1:0] wd);
    cmd_ch.valid <= 1'b0;
    wait (awaited_count == 0);
    repeat (4) @(negedge clk_i);
    write_reg(CFG_MAX_VX, {17'($urandom), lx});
    write_reg(CFG_MAX_VY, {17'($urandom), ly});
    write_reg(CFG_MAX_YAW, {17'($urandom), lyaw});
    write_reg(CFG_DEADBAND, {17'($urandom), db});
    write_reg(CFG_WD_PER, wd);
    write_reg(CFG_SPARE, CfgDataW'($urandom));
    cfg_ch.valid <= 1'b0;
    cur_lim_vx  = lx;
    cur_lim_vy  = ly;
    cur_lim_yaw = lyaw;
    cur_db      = db;
    cur_wd      = wd;
  endtask

  function automatic logic signed [SpeedW-1:0] pick_axis(input logic [LimitW-1:0] lim);
    int unsigned m;
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) m = 0;
    else if (sel == 1) m = $urandom_range(0, (cur_db < lim) ? cur_db : lim);
    else if (sel == 2) m = 32'(lim);
    else m = $urandom_range(0, lim);
    return $urandom_range(0, 1) ? -SpeedW'(m) : SpeedW'(m);
  endfunction

  // magnitude just past the limit, up to the most negative value
  function automatic logic signed [SpeedW-1:0] over_axis(input logic [LimitW-1:0] lim);
    int unsigned lo;
    int unsigned m;
    lo = 32'(lim);
    m  = $urandom_range(lo + 1, 32768);
    return $urandom_range(0, 1) ? -SpeedW'(m) : SpeedW'(m);
  endfunction

  task automatic random_command();
    int unsigned pick;
    int unsigned sel;
    logic signed [SpeedW-1:0] vx, vy, yaw;
    logic [TimeW-1:0] stamp;
    pick = $urandom_range(0, 99);
    vx   = SpeedW'($urandom);
    vy   = SpeedW'($urandom);
    yaw  = SpeedW'($urandom);
    if (pick < 45) begin
      vx  = pick_axis(cur_lim_vx);
      vy  = pick_axis(cur_lim_vy);
      yaw = pick_axis(cur_lim_yaw);
      clock_now       = clock_now + TimeW'($urandom_range(0, 8));
      last_sent_stamp = clock_now;
      offer_command(KIND_PACKET, 1'b0, vx, vy, yaw, clock_now);
    end else if (pick < 85) begin
      sel = $urandom_range(0, 19);
      if (sel < 3) begin
        // right at the watchdog edge
        stamp = last_sent_stamp + cur_wd - TimeW'($urandom_range(0, 1));
      end else if (sel < 5) begin
        stamp = last_sent_stamp - TimeW'($urandom_range(1, 16));
      end else begin
        clock_now = clock_now + TimeW'($urandom_range(0, cur_wd >> 2));
        stamp     = clock_now;
      end
      offer_command(KIND_TICK, 1'($urandom), vx, vy, yaw, stamp);
    end else if (pick < 92) begin
      offer_command(KIND_PACKET, 1'b1, vx, vy, yaw, clock_now);
    end else if (pick < 97) begin
      vx  = pick_axis(cur_lim_vx);
      vy  = pick_axis(cur_lim_vy);
      yaw = pick_axis(cur_lim_yaw);
      sel = $urandom_range(0, 2);
      if (sel == 0) vx = over_axis(cur_lim_vx);
      else if (sel == 1) vy = over_axis(cur_lim_vy);
      else yaw = over_axis(cur_lim_yaw);
      offer_command(KIND_PACKET, 1'b0, vx, vy, yaw, clock_now);
    end else begin
      offer_command(1'($urandom), 1'($urandom), vx, vy, yaw, TimeW'($urandom));
    end
  endtask

  initial begin
    logic [LimitW-1:0] lim;
    rst_ni              = 1'b0;
    cmd_ch.valid        = 1'b0;
    cmd_ch.kind         = KIND_PACKET;
    cmd_ch.format_error = 1'b0;
    cmd_ch.cmd_vx       = '0;
    cmd_ch.cmd_vy       = '0;
    cmd_ch.cmd_yaw      = '0;
    cmd_ch.now          = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = CFG_MAX_VX;
    cfg_ch.data         = '0;
    cur_lim_vx          = RST_MAX_VX;
    cur_lim_vy          = RST_MAX_VY;
    cur_lim_yaw         = RST_MAX_YAW;
    cur_db              = RST_DEADBAND;
    cur_wd              = RST_WD_PER;
    clock_now           = '0;
    last_sent_stamp     = '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset limits: vx 4096, vy 2048, yaw 4096, no deadband, period 500
    offer_command(KIND_TICK, 1'b0, 16'sd0, 16'sd0, 16'sd0, 32'd0);
    offer_command(KIND_PACKET, 1'b1, 16'sd100, 16'sd0, 16'sd0, 32'd10);
    offer_command(KIND_PACKET, 1'b0, 16'sh8000, 16'sd0, 16'sd0, 32'd20);
    offer_command(KIND_PACKET, 1'b0, 16'sd0, 16'sd0, 16'sd0, 32'd30);
    offer_command(KIND_PACKET, 1'b0, 16'sd4096, -16'sd2048, 16'sd4096, 32'd100);
    offer_command(KIND_TICK, 1'b0, 16'sd0, 16'sd0, 16'sd0, 32'd200);
    offer_command(KIND_TICK, 1'b0, 16'sd0, 16'sd0, 16'sd0, 32'd599);
    offer_command(KIND_TICK, 1'b0, 16'sd0, 16'sd0, 16'sd0, 32'd600);
    offer_command(KIND_TICK, 1'b0, 16'sd0, 16'sd0, 16'sd0, 32'd600);
    offer_command(KIND_PACKET, 1'b0, 16'sd4097, 16'sd0, 16'sd0, 32'd700);
    offer_command(KIND_PACKET, 1'b0, 16'sd1, 16'sd0, -16'sd1, 32'd1000);
    offer_command(KIND_PACKET, 1'b1, 16'sh8000, 16'sd0, 16'sd0, 32'd5000);
    offer_command(KIND_TICK, 1'b0, 16'sd0, 16'sd0, 16'sd0, 32'd1001);
    offer_command(KIND_PACKET, 1'b0, -16'sd4096, 16'sd0, 16'sd0, 32'd1000);
    offer_command(KIND_TICK, 1'b0, 16'sd0, 16'sd0, 16'sd0, 32'd999);
    offer_command(KIND_PACKET, 1'b0, 16'sd0, 16'sd2049, 16'sd0, 32'd1100);
    offer_command(KIND_PACKET, 1'b0, 16'sd0, 16'sd0, -16'sd4097, 32'd1200);
    offer_command(KIND_PACKET, 1'b0, 16'sd5, -16'sd2048, 16'sd0, 32'hFFFF_FFFF);
    // tick ignores the command fields
    offer_command(KIND_TICK, 1'b1, 16'shFFFF, 16'shFFFF, 16'shFFFF, 32'hFFFF_FFFF);
    offer_command(KIND_TICK, 1'b0, 16'sd0, 16'sd0, 16'sd0, 32'd0);

    // zero vx limit, wide deadband, zero watchdog period
    program_limits(15'd0, 15'h7FFF, 15'h7FFF, 15'd100, 32'd0);
    offer_command(KIND_PACKET, 1'b0, 16'sd0, 16'sd100, -16'sd100, 32'd5);
    offer_command(KIND_PACKET, 1'b0, 16'sd1, 16'sd0, 16'sd0, 32'd6);
    offer_command(KIND_PACKET, 1'b0, 16'sd0, 16'sd101, -16'sd32767, 32'd7);
    offer_command(KIND_TICK, 1'b0, 16'sd0, 16'sd0, 16'sd0, 32'd7);

    for (int unsigned round = 0; round < SettingRounds; round++) begin
      if (round < 2) begin
        send_idle_pct = 38;
        recv_idle_pct = 79;
      end else if (round < 4) begin
        send_idle_pct = 79;
        recv_idle_pct = 38;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (round)
        1: program_limits(15'h7FFF, 15'h7FFF, 15'h7FFF, 15'd0, 32'hFFFF_FFFF);
        2: program_limits(15'd1, 15'd1, 15'd1, 15'd0, 32'd1);
        3: program_limits(15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF,
                          TimeW'($urandom_range(16, 2000)));
        default: begin
          lim = LimitW'($urandom_range(256, 32767));
          program_limits(lim, LimitW'($urandom_range(256, 32767)),
                         LimitW'($urandom_range(256, 32767)),
                         LimitW'($urandom_range(0, lim >> 3)),
                         TimeW'($urandom_range(16, 2000)));
        end
      endcase
      // results held back while commands keep coming, so the input backs up
      if (round == 4) holds_requested++;
      repeat (RandomCommands / SettingRounds) random_command();
    end

    cmd_ch.valid <= 1'b0;
    wait (awaited_count == 0);
    repeat (8) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
